// ===== design/mst_pkg.sv =====
package mst_pkg;

    localparam int SLOTS    = 64;
    localparam int IDX_W    = 6;
    localparam int N_SUMS   = 6;

    // command codes
    localparam logic [3:0] CMD_ADD     = 4'd0;
    localparam logic [3:0] CMD_MARK    = 4'd1;
    localparam logic [3:0] CMD_LEAKCHK = 4'd2;
    localparam logic [3:0] CMD_SWEEP   = 4'd3;
    localparam logic [3:0] CMD_REMOVE  = 4'd4;
    localparam logic [3:0] CMD_REPORT  = 4'd5;
    localparam logic [3:0] CMD_PASS    = 4'd6;
    localparam logic [3:0] CMD_PHASE   = 4'd7;
    localparam logic [3:0] CMD_STAT    = 4'd8;

    // error codes
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_DUP  = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    // statistics select codes
    localparam logic [3:0] SEL_MARKED = 4'd12;

    typedef enum logic [2:0] {
        ST_EMPTY    = 3'd0,
        ST_UNMARKED = 3'd1,
        ST_MARKED   = 3'd2,
        ST_NEW      = 3'd3,
        ST_LEAK     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [31:0] handle;
        logic [31:0] alloc_size;
        logic [7:0]  node_type;
        logic [7:0]  phase_tag;
        logic [3:0]  stat_select;
    } t_in;

    typedef struct packed {
        logic [1:0]  error_code;
        logic [5:0]  slot_index;
        logic        leak_present;
        logic [31:0] leak_handle;
        logic [7:0]  leak_type;
        logic [31:0] leak_size;
        logic [7:0]  leak_origin_tag;
        logic [7:0]  leak_found_tag;
        logic [6:0]  new_leak_count;
        logic [6:0]  repeat_leak_count;
        logic [63:0] stat_value;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] handle;
        logic [31:0] bytes;
        logic [7:0]  kind;
        logic [7:0]  origin_tag;
        logic [7:0]  leak_tag;
        logic        leak_valid;
    } t_slot;

endpackage

// ===== design/mst_slot_ram.sv =====
module mst_slot_ram
    import mst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_slot            i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_slot            o_rdata
);

    t_slot      mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    t_slot      r_rdata;
    logic       r_rvalid;

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    // per-entry valid bits: unwritten entries read as empty / zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            r_rvalid <= r_valid[i_raddr];
        end
    end

    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

// ===== design/mark_sweep_allocation_tracker.sv =====
// Mark-and-sweep allocation tracker.
// Command channel: present an item on i_item with i_start high; it is taken
// at a rising edge where o_busy is low. Results appear on o_result for one
// cycle each, flagged by o_strobe; o_result.last marks the final one.
// The receiver cannot stall: every result must be taken as it comes.
// Start pass, start phase, read stat and unknown codes answer in the cycle
// after the transfer. Table commands walk the slot RAM one slot at a time
// (read, then modify/write back): add, mark and remove stop at the deciding
// slot; leak check and sweep visit every slot; report visits every slot and
// emits one result per leaked slot, or one empty result if none.
// Reset clears every slot to empty and the statistics counters at once
// (per-slot valid bits), so no clearing pass is needed.
module mark_sweep_allocation_tracker
    import mst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_item,
    output logic o_busy,
    output logic o_strobe,
    output t_out o_result
);

    t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_in   r_item, n_item;
    t_out  r_out, n_out;
    logic  r_strobe, n_strobe;
    t_out  r_pend, n_pend;
    logic  r_pend_v, n_pend_v;
    logic [6:0] r_fresh, n_fresh, r_again, n_again;
    logic [63:0] r_sums [N_SUMS];
    logic [63:0] n_sums [N_SUMS];
    logic [31:0] r_events [N_SUMS];
    logic [31:0] n_events [N_SUMS];
    logic [31:0] r_marked, n_marked;

    logic  ram_we;
    t_slot ram_wdata;
    t_slot rd;
    logic  last_slot;
    t_out  cur;

    mst_slot_ram u_ram (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (ram_we),
        .i_waddr(r_idx),
        .i_wdata(ram_wdata),
        .i_raddr(r_idx),
        .o_rdata(rd)
    );

    assign last_slot = (r_idx == IDX_W'(SLOTS - 1));
    assign o_busy    = (r_state != S_IDLE);
    assign o_strobe  = r_strobe;
    assign o_result  = r_out;

    // control and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_pend_v <= 1'b0;
            r_marked <= '0;
            for (int i = 0; i < N_SUMS; i++) begin
                r_sums[i]   <= '0;
                r_events[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_pend_v <= n_pend_v;
            r_marked <= n_marked;
            for (int i = 0; i < N_SUMS; i++) begin
                r_sums[i]   <= n_sums[i];
                r_events[i] <= n_events[i];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_item  <= n_item;
        r_out   <= n_out;
        r_pend  <= n_pend;
        r_fresh <= n_fresh;
        r_again <= n_again;
    end

    // report entry built from the slot just read
    always_comb begin
        cur                 = '0;
        cur.slot_index      = r_idx;
        cur.leak_present    = 1'b1;
        cur.leak_handle     = rd.handle;
        cur.leak_type       = rd.kind;
        cur.leak_size       = rd.bytes;
        cur.leak_origin_tag = rd.origin_tag;
        cur.leak_found_tag  = rd.leak_tag;
    end

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_item   = r_item;
        n_out    = r_out;
        n_strobe = 1'b0;
        n_pend   = r_pend;
        n_pend_v = r_pend_v;
        n_fresh  = r_fresh;
        n_again  = r_again;
        n_marked = r_marked;
        for (int i = 0; i < N_SUMS; i++) begin
            n_sums[i]   = r_sums[i];
            n_events[i] = r_events[i];
        end
        ram_we    = 1'b0;
        ram_wdata = rd;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item   = i_item;
                    n_idx    = '0;
                    n_fresh  = '0;
                    n_again  = '0;
                    n_pend_v = 1'b0;
                    n_out    = '0;
                    n_out.last = 1'b1;
                    priority case (i_item.cmd)
                        CMD_ADD, CMD_MARK, CMD_LEAKCHK, CMD_SWEEP, CMD_REMOVE,
                        CMD_REPORT: begin
                            n_state = S_READ;
                        end
                        CMD_PASS: begin
                            n_sums[4] = '0;   n_sums[5] = '0;
                            n_events[4] = '0; n_events[5] = '0;
                            n_strobe = 1'b1;
                        end
                        CMD_PHASE: begin
                            n_sums[2] = '0;   n_sums[3] = '0;
                            n_events[2] = '0; n_events[3] = '0;
                            n_marked = '0;
                            n_strobe = 1'b1;
                        end
                        CMD_STAT: begin
                            if (i_item.stat_select < 4'd6) begin
                                n_out.stat_value = r_sums[i_item.stat_select[2:0]];
                            end else if (i_item.stat_select < SEL_MARKED) begin
                                n_out.stat_value = {32'd0,
                                    r_events[3'(i_item.stat_select - 4'd6)]};
                            end else if (i_item.stat_select == SEL_MARKED) begin
                                n_out.stat_value = {32'd0, r_marked};
                            end
                            n_strobe = 1'b1;
                        end
                        default: begin
                            n_strobe = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                n_state = S_EVAL;
            end

            S_EVAL: begin
                n_state = last_slot ? S_IDLE : S_READ;
                n_idx   = r_idx + IDX_W'(1);
                priority case (r_item.cmd)
                    CMD_ADD: begin
                        if (rd.status == ST_EMPTY) begin
                            ram_we = 1'b1;
                            ram_wdata.status     = ST_NEW;
                            ram_wdata.handle     = r_item.handle;
                            ram_wdata.bytes      = r_item.alloc_size;
                            ram_wdata.kind       = r_item.node_type;
                            ram_wdata.origin_tag = '0;
                            for (int i = 0; i < 3; i++) begin
                                n_sums[2*i]   = r_sums[2*i] + 64'(r_item.alloc_size);
                                n_events[2*i] = r_events[2*i] + 32'd1;
                            end
                            n_out.slot_index = r_idx;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else if (last_slot) begin
                            n_out.error_code = ERR_FULL;
                            n_strobe = 1'b1;
                        end
                    end
                    CMD_MARK: begin
                        if (rd.handle == r_item.handle && rd.status == ST_UNMARKED) begin
                            ram_we = 1'b1;
                            ram_wdata.status = ST_MARKED;
                            n_marked = r_marked + 32'd1;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else if (rd.handle == r_item.handle
                                     && rd.status == ST_MARKED) begin
                            n_out.error_code = ERR_DUP;
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else if (last_slot) begin
                            n_strobe = 1'b1;
                        end
                    end
                    CMD_LEAKCHK: begin
                        if (rd.status == ST_NEW) begin
                            ram_we = 1'b1;
                            ram_wdata.status     = ST_UNMARKED;
                            ram_wdata.origin_tag = r_item.phase_tag;
                        end else if (rd.status == ST_UNMARKED) begin
                            ram_we = 1'b1;
                            ram_wdata.status     = ST_LEAK;
                            ram_wdata.leak_tag   = r_item.phase_tag;
                            ram_wdata.leak_valid = 1'b1;
                            n_fresh = r_fresh + 7'd1;
                            n_again = r_again + 7'(rd.leak_valid);
                        end else if (rd.status == ST_MARKED) begin
                            ram_we = 1'b1;
                            ram_wdata.status = ST_UNMARKED;
                        end
                        if (last_slot) begin
                            n_out.new_leak_count    = n_fresh;
                            n_out.repeat_leak_count = n_again;
                            n_strobe = 1'b1;
                        end
                    end
                    CMD_SWEEP, CMD_REMOVE: begin
                        if ((r_item.cmd == CMD_SWEEP && rd.status == ST_UNMARKED)
                            || (r_item.cmd == CMD_REMOVE && rd.status != ST_EMPTY
                                && rd.handle == r_item.handle)) begin
                            // free the slot; leak history stays
                            ram_we = 1'b1;
                            ram_wdata.status     = ST_EMPTY;
                            ram_wdata.handle     = '0;
                            ram_wdata.bytes      = '0;
                            ram_wdata.kind       = '0;
                            ram_wdata.origin_tag = '0;
                            for (int i = 0; i < 3; i++) begin
                                n_sums[2*i+1]   = r_sums[2*i+1] + 64'(rd.bytes);
                                n_events[2*i+1] = r_events[2*i+1] + 32'd1;
                            end
                            if (r_item.cmd == CMD_REMOVE) begin
                                n_strobe = 1'b1;
                                n_state  = S_IDLE;
                            end
                        end else if (r_item.cmd == CMD_SWEEP
                                     && (rd.status == ST_MARKED || rd.status == ST_NEW)) begin
                            ram_we = 1'b1;
                            ram_wdata.status = ST_UNMARKED;
                        end
                        if (last_slot) begin
                            n_strobe = 1'b1;
                        end
                    end
                    default: begin
                        // report: hold one entry back so last can be set
                        if (rd.status == ST_LEAK) begin
                            if (r_pend_v) begin
                                n_out    = r_pend;
                                n_strobe = 1'b1;
                            end
                            n_pend   = cur;
                            n_pend_v = 1'b1;
                        end
                        if (last_slot) begin
                            n_state = S_FLUSH;
                        end
                    end
                endcase
            end

            S_FLUSH: begin
                n_out = '0;
                if (r_pend_v) begin
                    n_out = r_pend;
                end
                n_out.last = 1'b1;
                n_strobe = 1'b1;
                n_pend_v = 1'b0;
                n_state  = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
